>>> rtl/ctm_pkg.sv
// Shared constants, types and register codes of the cascaded trimmed-mean load and speed filter.
`default_nettype none

package ctm_pkg;

    // Default build of the filter
    localparam int WINDOW_TAPS      = 5;
    localparam int FILTER_STAGES    = 5;
    localparam int READINGS_PER_SUM = 25;
    localparam int FRACTION_BITS    = 8;

    // Field widths
    localparam int ADC_W       = 15;
    localparam int PHASE_W     = 15;
    localparam int PHASE_SUM_W = 16;
    localparam int MV_SCALE_W  = 24;
    localparam int ZLIM_W      = 8;
    localparam int MINP_W      = 8;
    localparam int MAXP_W      = 15;
    localparam int COUNTS_W    = 11;
    localparam int MV_W        = 20;
    localparam int HZ_W        = 24;
    localparam int NP_W        = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // Average reading above this is out of range
    localparam int LOAD_LIMIT  = 1024;
    // mv_scale has 24 fractional bits, millivolts keep 16
    localparam int MV_DROP     = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [MV_W-1:0]  MV_MAX = '1;
    localparam logic [HZ_W-1:0]  HZ_MAX = '1;
    localparam logic [NP_W-1:0]  NP_MAX = '1;

    localparam logic [MV_SCALE_W-1:0] MV_SCALE_RESET  = 24'd165676;
    localparam logic [ZLIM_W-1:0]     ZERO_LIM_RESET  = 8'd10;
    localparam logic [MINP_W-1:0]     MIN_PHASE_RESET = 8'd1;
    localparam logic [MAXP_W-1:0]     MAX_PHASE_RESET = 15'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MV_SCALE,
        CFG_ZERO_LIMIT,
        CFG_MIN_PHASE,
        CFG_MAX_PHASE
    } t_cfg_idx;

    typedef struct packed {
        logic [MV_SCALE_W-1:0] mv_scale;
        logic [ZLIM_W-1:0]     zero_window_limit;
        logic [MINP_W-1:0]     min_phase_count;
        logic [MAXP_W-1:0]     max_phase_count;
    } t_cfg;

    // What the speed path does with one item
    typedef enum logic [1:0] {
        SPD_NONE,
        SPD_UPD,
        SPD_ZERO
    } t_spd_op;

    typedef struct packed {
        logic    load_upd;
        t_spd_op spd_op;
    } t_cmd;

    typedef struct packed {
        logic adv;
        logic shift;
        logic clear;
    } t_win_ctl;

endpackage

`default_nettype wire

>>> rtl/ctm_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface ctm_in_if;
    logic                        valid;
    logic                        ready;
    logic [ctm_pkg::ADC_W-1:0]   adc_sum;
    logic [ctm_pkg::PHASE_W-1:0] high_count;
    logic [ctm_pkg::PHASE_W-1:0] low_count;

    modport source (output valid, output adc_sum, output high_count, output low_count,
                    input ready);
    modport sink   (input valid, input adc_sum, input high_count, input low_count,
                    output ready);
endinterface

interface ctm_out_if;
    logic                         valid;
    logic                         ready;
    logic                         load_valid;
    logic [ctm_pkg::COUNTS_W-1:0] load_counts;
    logic [ctm_pkg::MV_W-1:0]     load_millivolts;
    logic                         speed_valid;
    logic [ctm_pkg::HZ_W-1:0]     speed_hz;
    logic                         speed_zeroed;

    modport source (output valid, output load_valid, output load_counts,
                    output load_millivolts, output speed_valid, output speed_hz,
                    output speed_zeroed, input ready);
    modport sink   (input valid, input load_valid, input load_counts,
                    input load_millivolts, input speed_valid, input speed_hz,
                    input speed_zeroed, output ready);
endinterface

`default_nettype wire

>>> rtl/cascaded_trimmed_mean_load_and_speed.sv
// Top level of the cascaded trimmed-mean load and speed filter.
//
// Input channel i_in carries one item per transfer: adc_sum (sum of the load-cell
// readings) and the tacho window's high_count and low_count. Output channel o_out
// carries one result per item, in order: load_valid/load_counts/load_millivolts and
// speed_valid/speed_hz/speed_zeroed. Both use valid/ready; a transfer happens on a
// rising edge with both high.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data: 0 mv_scale,
// 1 zero_window_limit, 2 min_phase_count, 3 max_phase_count. Write only while idle.
// Throughput: one item per cycle while o_out is not stalled. Each window stage
// registers sum/min/max, then the reciprocal multiply; the front register, queue
// hop, millivolt multiply and output register lie between input and result.
// When o_out stalls, the pipeline holds; the front keeps taking items until the
// QUEUE_DEPTH-entry queue and its input register are full, then drops ready.
// Reset (synchronous, active low): registers go to defaults, all window taps and
// the no-pulse counter clear, nothing is in flight. No clearing pass is needed.
`default_nettype none

module cascaded_trimmed_mean_load_and_speed #(
    parameter int WINDOW_TAPS      = ctm_pkg::WINDOW_TAPS,
    parameter int FILTER_STAGES    = ctm_pkg::FILTER_STAGES,
    parameter int READINGS_PER_SUM = ctm_pkg::READINGS_PER_SUM,
    parameter int FRACTION_BITS    = ctm_pkg::FRACTION_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    ctm_in_if.sink                                i_in,
    ctm_out_if.source                             o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [ctm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [ctm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int LOAD_W = ctm_pkg::COUNTS_W + FRACTION_BITS;
    localparam int SPD_W  = ctm_pkg::PHASE_SUM_W + FRACTION_BITS;
    localparam int CMD_W  = $bits(ctm_pkg::t_cmd);
    localparam int QW     = CMD_W + LOAD_W + SPD_W;

    ctm_pkg::t_cfg      r_cfg;

    logic               f_push;
    ctm_pkg::t_cmd      f_cmd;
    logic [LOAD_W-1:0]  f_load;
    logic [SPD_W-1:0]   f_spd;

    logic [QW-1:0]      q_in;
    logic [QW-1:0]      q_out;
    logic               q_empty;
    logic               q_full;
    logic               q_pop;

    // Configuration registers: take each write at the edge, keep the field's own width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mv_scale          <= ctm_pkg::MV_SCALE_RESET;
            r_cfg.zero_window_limit <= ctm_pkg::ZERO_LIM_RESET;
            r_cfg.min_phase_count   <= ctm_pkg::MIN_PHASE_RESET;
            r_cfg.max_phase_count   <= ctm_pkg::MAX_PHASE_RESET;
        end else if (i_cfg_we) begin
            unique case (ctm_pkg::t_cfg_idx'(i_cfg_idx))
                ctm_pkg::CFG_MV_SCALE: begin
                    r_cfg.mv_scale <= i_cfg_data[ctm_pkg::MV_SCALE_W-1:0];
                end
                ctm_pkg::CFG_ZERO_LIMIT: begin
                    r_cfg.zero_window_limit <= i_cfg_data[ctm_pkg::ZLIM_W-1:0];
                end
                ctm_pkg::CFG_MIN_PHASE: begin
                    r_cfg.min_phase_count <= i_cfg_data[ctm_pkg::MINP_W-1:0];
                end
                ctm_pkg::CFG_MAX_PHASE: begin
                    r_cfg.max_phase_count <= i_cfg_data[ctm_pkg::MAXP_W-1:0];
                end
            endcase
        end
    end

    // Front: accept, classify, count no-pulse windows, scale the average
    ctm_front #(
        .READINGS_PER_SUM (READINGS_PER_SUM),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (f_push),
        .o_cmd    (f_cmd),
        .o_load   (f_load),
        .o_spd    (f_spd)
    );

    assign q_in = {f_cmd, f_load, f_spd};

    // Decouple the two sides so each can stall on its own
    ctm_queue #(
        .WIDTH (QW),
        .DEPTH (ctm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Back: window cascades, millivolt scaling, output register
    ctm_back #(
        .WINDOW_TAPS   (WINDOW_TAPS),
        .FILTER_STAGES (FILTER_STAGES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_vld  (!q_empty),
        .i_q_cmd  (ctm_pkg::t_cmd'(q_out[QW-1 -: CMD_W])),
        .i_q_load (q_out[SPD_W +: LOAD_W]),
        .i_q_spd  (q_out[SPD_W-1:0]),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

>>> rtl/ctm_queue.sv
// Short FIFO between the classifying front end and the filter pipeline.
`default_nettype none

module ctm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> rtl/ctm_front.sv
// Front end: accept items, classify load and speed paths, scale the average reading.
`default_nettype none

module ctm_front #(
    parameter int READINGS_PER_SUM = ctm_pkg::READINGS_PER_SUM,
    parameter int FRACTION_BITS    = ctm_pkg::FRACTION_BITS,
    localparam int LOAD_W = ctm_pkg::COUNTS_W + FRACTION_BITS,
    localparam int SPD_W  = ctm_pkg::PHASE_SUM_W + FRACTION_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  ctm_pkg::t_cfg      i_cfg,
    ctm_in_if.sink             i_in,
    input  wire logic          i_q_full,
    output logic               o_push,
    output ctm_pkg::t_cmd      o_cmd,
    output logic [LOAD_W-1:0]  o_load,
    output logic [SPD_W-1:0]   o_spd
);

    localparam int NUM_W = ctm_pkg::ADC_W + FRACTION_BITS;
    localparam int KA    = NUM_W + $clog2(READINGS_PER_SUM);
    localparam logic [63:0] RECIP64 =
        ((64'd1 << KA) + 64'(READINGS_PER_SUM) - 64'd1) / 64'(READINGS_PER_SUM);
    localparam logic [KA:0] RECIP = RECIP64[KA:0];
    localparam int PW = NUM_W + KA + 1;
    localparam logic [ctm_pkg::ADC_W:0] LOAD_CAP =
        (ctm_pkg::ADC_W + 1)'(ctm_pkg::LOAD_LIMIT * READINGS_PER_SUM);

    logic                      accept;
    logic                      no_pulse;
    logic                      below_max;
    logic [ctm_pkg::NP_W-1:0]  n_np_cnt;
    ctm_pkg::t_cmd             n_cmd;
    logic [SPD_W-1:0]          n_spd;
    logic [NUM_W-1:0]          num;

    logic                      r_f_vld;
    logic [ctm_pkg::NP_W-1:0]  r_np_cnt;
    ctm_pkg::t_cmd             r_cmd;
    logic [PW-1:0]             r_avg_prod;
    logic [SPD_W-1:0]          r_spd;

    assign i_in.ready = !r_f_vld || !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = r_f_vld && !i_q_full;

    assign no_pulse  = (i_in.high_count <= ctm_pkg::PHASE_W'(i_cfg.min_phase_count)) ||
                       (i_in.low_count  <= ctm_pkg::PHASE_W'(i_cfg.min_phase_count));
    assign below_max = (i_in.high_count < i_cfg.max_phase_count) ||
                       (i_in.low_count  < i_cfg.max_phase_count);

    always_comb begin
        n_cmd.load_upd = ({1'b0, i_in.adc_sum} <= LOAD_CAP);
        if (no_pulse) begin
            // count the no-pulse window, hold at full scale
            n_np_cnt = (r_np_cnt == ctm_pkg::NP_MAX) ? r_np_cnt : r_np_cnt + 1'b1;
            n_cmd.spd_op = (n_np_cnt > i_cfg.zero_window_limit) ? ctm_pkg::SPD_ZERO
                                                                : ctm_pkg::SPD_NONE;
        end else begin
            n_np_cnt = '0;
            n_cmd.spd_op = below_max ? ctm_pkg::SPD_UPD : ctm_pkg::SPD_NONE;
        end
    end

    assign num   = NUM_W'(i_in.adc_sum) << FRACTION_BITS;
    assign n_spd = SPD_W'(ctm_pkg::PHASE_SUM_W'(i_in.high_count) +
                          ctm_pkg::PHASE_SUM_W'(i_in.low_count)) << FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld  <= 1'b0;
            r_np_cnt <= '0;
        end else begin
            if (accept) begin
                r_f_vld  <= 1'b1;
                r_np_cnt <= n_np_cnt;
            end else if (o_push) begin
                r_f_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= n_cmd;
            r_avg_prod <= PW'(num) * PW'(RECIP);
            r_spd      <= n_spd;
        end
    end

    assign o_cmd  = r_cmd;
    assign o_load = r_avg_prod[KA +: LOAD_W];
    assign o_spd  = r_spd;

endmodule

`default_nettype wire

>>> rtl/ctm_window.sv
// One trimmed-mean window stage: shift in, sum/min/max, then divide by taps minus two.
`default_nettype none

module ctm_window #(
    parameter int W    = 24,
    parameter int TAPS = 5
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  ctm_pkg::t_win_ctl   i_ctl,
    input  wire logic [W-1:0]   i_value,
    output logic      [W-1:0]   o_value
);

    localparam int SW  = W + $clog2(TAPS);
    localparam int DIV = TAPS - 2;
    localparam int K   = SW + $clog2(DIV);
    localparam logic [63:0] RECIP64 = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [K:0] RECIP = RECIP64[K:0];
    localparam int PW = SW + K + 1;

    logic [W-1:0]  r_taps [TAPS];
    logic [W-1:0]  w_next [TAPS];
    logic [SW-1:0] sum_c;
    logic [W-1:0]  min_c;
    logic [W-1:0]  max_c;
    logic [SW-1:0] trim;
    logic [SW-1:0] r_sum;
    logic [W-1:0]  r_min;
    logic [W-1:0]  r_max;
    logic [PW-1:0] r_prod;

    always_comb begin
        for (int i = 0; i < TAPS - 1; i++) begin
            w_next[i] = r_taps[i + 1];
        end
        w_next[TAPS - 1] = i_value;
    end

    always_comb begin
        sum_c = '0;
        min_c = w_next[0];
        max_c = w_next[0];
        for (int i = 0; i < TAPS; i++) begin
            sum_c = sum_c + SW'(w_next[i]);
            if (w_next[i] < min_c) begin
                min_c = w_next[i];
            end
            if (w_next[i] > max_c) begin
                max_c = w_next[i];
            end
        end
    end

    assign trim = r_sum - SW'(r_min) - SW'(r_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_taps[i] <= '0;
            end
        end else if (i_ctl.adv) begin
            if (i_ctl.clear) begin
                for (int i = 0; i < TAPS; i++) begin
                    r_taps[i] <= '0;
                end
            end else if (i_ctl.shift) begin
                r_taps <= w_next;
            end
        end
    end

    // divide by a constant: multiply by the rounded-up reciprocal, keep the high bits
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_sum  <= sum_c;
            r_min  <= min_c;
            r_max  <= max_c;
            r_prod <= PW'(trim) * PW'(RECIP);
        end
    end

    assign o_value = r_prod[K +: W];

endmodule

`default_nettype wire

>>> rtl/ctm_back.sv
// Back end: cascaded window stages for both paths, millivolt scaling and the output register.
`default_nettype none

module ctm_back #(
    parameter int WINDOW_TAPS   = ctm_pkg::WINDOW_TAPS,
    parameter int FILTER_STAGES = ctm_pkg::FILTER_STAGES,
    parameter int FRACTION_BITS = ctm_pkg::FRACTION_BITS,
    localparam int LOAD_W = ctm_pkg::COUNTS_W + FRACTION_BITS,
    localparam int SPD_W  = ctm_pkg::PHASE_SUM_W + FRACTION_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  ctm_pkg::t_cfg          i_cfg,
    input  wire logic              i_q_vld,
    input  ctm_pkg::t_cmd          i_q_cmd,
    input  wire logic [LOAD_W-1:0] i_q_load,
    input  wire logic [SPD_W-1:0]  i_q_spd,
    output logic                   o_pop,
    ctm_out_if.source              o_out
);

    localparam int LINE      = 2 * FILTER_STAGES + 1;
    localparam int HZ_EXT    = (SPD_W > ctm_pkg::HZ_W) ? SPD_W : ctm_pkg::HZ_W;
    localparam int MV_PROD_W = ctm_pkg::COUNTS_W + ctm_pkg::MV_SCALE_W;
    localparam int MV_SH_W   = MV_PROD_W - ctm_pkg::MV_DROP;

    logic                       adv;
    logic                       r_vld [LINE];
    ctm_pkg::t_cmd              r_cmd [LINE];

    logic                       stg_vld  [FILTER_STAGES];
    ctm_pkg::t_cmd              stg_cmd  [FILTER_STAGES];
    logic [LOAD_W-1:0]          load_in  [FILTER_STAGES];
    logic [LOAD_W-1:0]          load_out [FILTER_STAGES];
    logic [SPD_W-1:0]           spd_in   [FILTER_STAGES];
    logic [SPD_W-1:0]           spd_out  [FILTER_STAGES];
    ctm_pkg::t_win_ctl          ld_ctl   [FILTER_STAGES];
    ctm_pkg::t_win_ctl          sp_ctl   [FILTER_STAGES];

    logic [ctm_pkg::COUNTS_W-1:0] counts_c;
    logic [HZ_EXT-1:0]            hz_ext;
    logic [ctm_pkg::HZ_W-1:0]     hz_sat;
    logic [MV_SH_W-1:0]           mv_sh;
    logic [ctm_pkg::MV_W-1:0]     mv_sat;

    logic [ctm_pkg::COUNTS_W-1:0] r_counts;
    logic [MV_PROD_W-1:0]         r_mv_prod;
    logic [ctm_pkg::HZ_W-1:0]     r_hz;

    logic                         r_out_valid;
    logic                         r_load_valid;
    logic [ctm_pkg::COUNTS_W-1:0] r_load_counts;
    logic [ctm_pkg::MV_W-1:0]     r_load_mv;
    logic                         r_speed_valid;
    logic [ctm_pkg::HZ_W-1:0]     r_speed_hz;
    logic                         r_speed_zeroed;

    // whole pipeline moves when the output slot is free or being taken
    assign adv   = !r_out_valid || o_out.ready;
    assign o_pop = adv && i_q_vld;

    for (genvar s = 0; s < FILTER_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_head
            assign stg_vld[s] = i_q_vld;
            assign stg_cmd[s] = i_q_cmd;
            assign load_in[s] = i_q_load;
            assign spd_in[s]  = i_q_spd;
        end else begin : g_tail
            assign stg_vld[s] = r_vld[2 * s - 1];
            assign stg_cmd[s] = r_cmd[2 * s - 1];
            assign load_in[s] = load_out[s - 1];
            assign spd_in[s]  = spd_out[s - 1];
        end

        assign ld_ctl[s] = '{adv: adv,
                             shift: stg_vld[s] && stg_cmd[s].load_upd,
                             clear: 1'b0};
        assign sp_ctl[s] = '{adv: adv,
                             shift: stg_vld[s] && (stg_cmd[s].spd_op == ctm_pkg::SPD_UPD),
                             clear: stg_vld[s] && (stg_cmd[s].spd_op == ctm_pkg::SPD_ZERO)};

        ctm_window #(.W(LOAD_W), .TAPS(WINDOW_TAPS)) u_load_win (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ld_ctl[s]),
            .i_value (load_in[s]),
            .o_value (load_out[s])
        );

        ctm_window #(.W(SPD_W), .TAPS(WINDOW_TAPS)) u_spd_win (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (sp_ctl[s]),
            .i_value (spd_in[s]),
            .o_value (spd_out[s])
        );
    end

    assign counts_c = load_out[FILTER_STAGES - 1][FRACTION_BITS +: ctm_pkg::COUNTS_W];
    assign hz_ext   = HZ_EXT'(spd_out[FILTER_STAGES - 1]);
    assign hz_sat   = (hz_ext > HZ_EXT'(ctm_pkg::HZ_MAX)) ? ctm_pkg::HZ_MAX
                                                          : hz_ext[ctm_pkg::HZ_W-1:0];
    assign mv_sh    = r_mv_prod[MV_PROD_W-1:ctm_pkg::MV_DROP];
    assign mv_sat   = (mv_sh > MV_SH_W'(ctm_pkg::MV_MAX)) ? ctm_pkg::MV_MAX
                                                          : mv_sh[ctm_pkg::MV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LINE; j++) begin
                r_vld[j] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_q_vld;
            for (int j = 1; j < LINE; j++) begin
                r_vld[j] <= r_vld[j - 1];
            end
            r_out_valid <= r_vld[LINE - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cmd[0] <= i_q_cmd;
            for (int j = 1; j < LINE; j++) begin
                r_cmd[j] <= r_cmd[j - 1];
            end
            r_counts  <= counts_c;
            r_mv_prod <= MV_PROD_W'(counts_c) * MV_PROD_W'(i_cfg.mv_scale);
            r_hz      <= hz_sat;
            if (r_vld[LINE - 1]) begin
                r_load_valid  <= r_cmd[LINE - 1].load_upd;
                r_load_counts <= r_cmd[LINE - 1].load_upd ? r_counts : '0;
                r_load_mv     <= r_cmd[LINE - 1].load_upd ? mv_sat : '0;
                unique case (r_cmd[LINE - 1].spd_op)
                    ctm_pkg::SPD_UPD: begin
                        r_speed_valid  <= 1'b1;
                        r_speed_hz     <= r_hz;
                        r_speed_zeroed <= 1'b0;
                    end
                    ctm_pkg::SPD_ZERO: begin
                        r_speed_valid  <= 1'b1;
                        r_speed_hz     <= '0;
                        r_speed_zeroed <= 1'b1;
                    end
                    default: begin
                        r_speed_valid  <= 1'b0;
                        r_speed_hz     <= '0;
                        r_speed_zeroed <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.load_valid      = r_load_valid;
    assign o_out.load_counts     = r_load_counts;
    assign o_out.load_millivolts = r_load_mv;
    assign o_out.speed_valid     = r_speed_valid;
    assign o_out.speed_hz        = r_speed_hz;
    assign o_out.speed_zeroed    = r_speed_zeroed;

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_speed_zeroed |-> r_speed_valid && (r_speed_hz == '0))
        else $error("forced-zero speed result carries a value");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_load_valid |-> (r_load_counts == '0) && (r_load_mv == '0))
        else $error("load fields set without a load update");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the cascaded trimmed-mean load and speed filter.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ctm_pkg::*;

    // Cycles without any transfer before the run is declared hung. The longest
    // legitimate quiet stretch is the receiver hold-off.
    localparam int STALL_LIMIT = 4000;
    // Input-to-result latency, used with a margin for the final wait for stray results
    localparam int PIPE_LATENCY = 2 * FILTER_STAGES + 3;
    localparam int LOAD_FULL    = LOAD_LIMIT * READINGS_PER_SUM;
    localparam int PHASE_MAX    = (1 << PHASE_W) - 1;
    localparam int LOAD_PATH    = 0;
    localparam int SPEED_PATH   = 1;
    localparam int PRINT_CAP    = 40;

    // One result item as the block presents it on o_out
    typedef struct packed {
        logic                load_valid;
        logic [COUNTS_W-1:0] load_counts;
        logic [MV_W-1:0]     load_millivolts;
        logic                speed_valid;
        logic [HZ_W-1:0]     speed_hz;
        logic                speed_zeroed;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ctm_in_if  in_ch ();
    ctm_out_if out_ch ();

    cascaded_trimmed_mean_load_and_speed dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Filter predictor: shadow registers, window taps for both paths and
    // the no-pulse run counter, updated once per accepted input transfer.
    // ------------------------------------------------------------------
    t_cfg            cfg_now;
    logic [HZ_W-1:0] taps [2][FILTER_STAGES][WINDOW_TAPS];
    logic [NP_W-1:0] quiet_windows;
    t_result         pending_results [$];

    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned load_updates;
    int unsigned speed_updates;
    int unsigned speed_timeouts;
    int unsigned mismatches;

    // Shift v through every stage of one path; each stage drops its
    // smallest and largest tap and averages the rest (truncated).
    function automatic logic [HZ_W-1:0] cascade_push(input int path, input logic [HZ_W-1:0] v);
        logic [HZ_W-1:0] stage_in;
        logic [HZ_W-1:0] lo;
        logic [HZ_W-1:0] hi;
        logic [63:0]     acc;
        stage_in = v;
        for (int s = 0; s < FILTER_STAGES; s++) begin
            for (int t = 0; t < WINDOW_TAPS - 1; t++) begin
                taps[path][s][t] = taps[path][s][t+1];
            end
            taps[path][s][WINDOW_TAPS-1] = stage_in;
            lo  = taps[path][s][0];
            hi  = lo;
            acc = '0;
            for (int t = 0; t < WINDOW_TAPS; t++) begin
                acc += 64'(taps[path][s][t]);
                if (taps[path][s][t] < lo) lo = taps[path][s][t];
                if (taps[path][s][t] > hi) hi = taps[path][s][t];
            end
            acc      = acc - 64'(lo) - 64'(hi);
            stage_in = HZ_W'(acc / 64'(WINDOW_TAPS - 2));
        end
        return stage_in;
    endfunction

    function automatic void clear_path(input int path);
        for (int s = 0; s < FILTER_STAGES; s++) begin
            for (int t = 0; t < WINDOW_TAPS; t++) begin
                taps[path][s][t] = '0;
            end
        end
    endfunction

    function automatic void reset_predictor();
        cfg_now.mv_scale          = MV_SCALE_RESET;
        cfg_now.zero_window_limit = ZERO_LIM_RESET;
        cfg_now.min_phase_count   = MIN_PHASE_RESET;
        cfg_now.max_phase_count   = MAX_PHASE_RESET;
        clear_path(LOAD_PATH);
        clear_path(SPEED_PATH);
        quiet_windows = '0;
    endfunction

    function automatic t_result predict_filter(input logic [ADC_W-1:0] adc,
                                               input logic [PHASE_W-1:0] hc,
                                               input logic [PHASE_W-1:0] lc);
        t_result           r;
        logic [HZ_W-1:0]   filtered;
        logic [COUNTS_W-1:0] counts;
        logic [63:0]       mv_full;
        r = '0;

        // Load path: skip entirely when the average reading is over range
        if (int'(adc) <= LOAD_FULL) begin
            filtered = cascade_push(LOAD_PATH,
                                    HZ_W'((32'(adc) << FRACTION_BITS) / READINGS_PER_SUM));
            counts   = COUNTS_W'(filtered >> FRACTION_BITS);
            mv_full  = (64'(counts) * 64'(cfg_now.mv_scale)) >> MV_DROP;
            r.load_valid      = 1'b1;
            r.load_counts     = counts;
            r.load_millivolts = (mv_full > 64'(MV_MAX)) ? MV_MAX : MV_W'(mv_full);
            load_updates++;
        end

        // Speed path: no-pulse windows count up, pulses restart the count
        if (hc <= cfg_now.min_phase_count || lc <= cfg_now.min_phase_count) begin
            if (quiet_windows != NP_MAX) quiet_windows++;
            if (quiet_windows > cfg_now.zero_window_limit) begin
                clear_path(SPEED_PATH);
                r.speed_valid  = 1'b1;
                r.speed_zeroed = 1'b1;
                speed_timeouts++;
            end
        end else begin
            quiet_windows = '0;
            if (hc < cfg_now.max_phase_count || lc < cfg_now.max_phase_count) begin
                r.speed_hz    = cascade_push(SPEED_PATH,
                                             HZ_W'((32'(hc) + 32'(lc)) << FRACTION_BITS));
                r.speed_valid = 1'b1;
                speed_updates++;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting: print a bounded number of lines, count them all
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        if (mismatches < PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input int unsigned idx, input string field,
                               input longint unsigned got, input longint unsigned want);
        if (got != want) begin
            flag_error($sformatf("result %0d %s: got %0d, want %0d", idx, field, got, want));
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare every accepted result with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
                want = pending_results.pop_front();
                check_field(results_seen, "load_valid", out_ch.load_valid, want.load_valid);
                check_field(results_seen, "load_counts", out_ch.load_counts, want.load_counts);
                check_field(results_seen, "load_millivolts", out_ch.load_millivolts,
                            want.load_millivolts);
                check_field(results_seen, "speed_valid", out_ch.speed_valid, want.speed_valid);
                check_field(results_seen, "speed_hz", out_ch.speed_hz, want.speed_hz);
                check_field(results_seen, "speed_zeroed", out_ch.speed_zeroed, want.speed_zeroed);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall at random, or hold off for a counted stretch when a
    // test asks for it.
    // ------------------------------------------------------------------
    int unsigned rx_idle_pct;
    int unsigned tx_idle_pct;
    int unsigned rx_hold_left;

    always @(negedge i_clk) begin
        if (rx_hold_left != 0) begin
            out_ch.ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: any transfer on either channel restarts the count
    int unsigned stall_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_results.size());
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Offer one item, idling first at random; predict it on the transfer.
    // Valid stays high on return so back-to-back items stream without gaps.
    task automatic send_item(input logic [ADC_W-1:0] adc, input logic [PHASE_W-1:0] hc,
                             input logic [PHASE_W-1:0] lc);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.adc_sum    <= adc;
        in_ch.high_count <= hc;
        in_ch.low_count  <= lc;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(predict_filter(adc, hc, lc));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write all four registers on consecutive cycles; call only when drained
    task automatic apply_config(input t_cfg c);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MV_SCALE;
        i_cfg_data <= CFG_DATA_W'(c.mv_scale);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_ZERO_LIMIT;
        i_cfg_data <= CFG_DATA_W'(c.zero_window_limit);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MIN_PHASE;
        i_cfg_data <= CFG_DATA_W'(c.min_phase_count);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MAX_PHASE;
        i_cfg_data <= CFG_DATA_W'(c.max_phase_count);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_now = c;
    endtask

    function automatic t_cfg default_config();
        t_cfg c;
        c.mv_scale          = MV_SCALE_RESET;
        c.zero_window_limit = ZERO_LIM_RESET;
        c.min_phase_count   = MIN_PHASE_RESET;
        c.max_phase_count   = MAX_PHASE_RESET;
        return c;
    endfunction

    function automatic int unsigned pick_setting(input int unsigned lo, input int unsigned hi,
                                                 input int unsigned dflt);
        case ($urandom_range(5))
            0:       return lo;
            1:       return hi;
            2, 3:    return dflt;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic t_cfg random_config();
        t_cfg c;
        c.mv_scale          = MV_SCALE_W'(pick_setting(0, (1 << MV_SCALE_W) - 1,
                                                       MV_SCALE_RESET));
        c.zero_window_limit = ZLIM_W'(pick_setting(0, (1 << ZLIM_W) - 1, ZERO_LIM_RESET));
        c.min_phase_count   = MINP_W'(pick_setting(0, (1 << MINP_W) - 1, MIN_PHASE_RESET));
        c.max_phase_count   = MAXP_W'(pick_setting(0, (1 << MAXP_W) - 1, MAX_PHASE_RESET));
        return c;
    endfunction

    // Phase count near a level, kept above the no-pulse threshold
    function automatic logic [PHASE_W-1:0] phase_near(input int unsigned level);
        int v;
        v = int'(level) + int'($urandom_range(60)) - 30;
        if (v <= int'(cfg_now.min_phase_count)) v = int'(cfg_now.min_phase_count) + 1;
        if (v > PHASE_MAX) v = PHASE_MAX;
        return PHASE_W'(v);
    endfunction

    // Random items come in runs around a held load level and speed level so
    // the cascades settle, with no-pulse runs that can reach the timeout for limits
    // under 40, and a sprinkling of full-range noise.
    int unsigned run_left;
    int unsigned load_level;
    int unsigned speed_level;
    int unsigned quiet_left;

    task automatic make_random_item(output logic [ADC_W-1:0] adc,
                                    output logic [PHASE_W-1:0] hc,
                                    output logic [PHASE_W-1:0] lc);
        int                 v;
        int unsigned        run_cap;
        logic [PHASE_W-1:0] quiet;
        logic [PHASE_W-1:0] other;
        if (run_left == 0) begin
            run_left = $urandom_range(40, 4);
            case ($urandom_range(3))
                0:       load_level = 0;
                1:       load_level = LOAD_FULL;
                default: load_level = $urandom_range(LOAD_FULL);
            endcase
            speed_level = ($urandom_range(4) == 0) ? $urandom_range(PHASE_MAX)
                                                   : $urandom_range(600, 2);
            if ($urandom_range(2) == 0) begin
                run_cap    = (cfg_now.zero_window_limit < 36) ?
                             int'(cfg_now.zero_window_limit) + 4 : 40;
                quiet_left = $urandom_range(run_cap, 1);
            end
        end
        run_left--;

        if ($urandom_range(99) < 6) begin
            adc = ADC_W'($urandom);
        end else begin
            v = int'(load_level) + int'($urandom_range(400)) - 200;
            if (v < 0) v = 0;
            if (v > LOAD_FULL) v = LOAD_FULL;
            adc = ADC_W'(v);
        end

        if (quiet_left != 0) begin
            quiet_left--;
            quiet = PHASE_W'($urandom_range(cfg_now.min_phase_count));
            other = PHASE_W'($urandom);
            if ($urandom_range(1) == 0) begin
                hc = quiet;
                lc = other;
            end else begin
                hc = other;
                lc = quiet;
            end
        end else if ($urandom_range(99) < 6) begin
            hc = PHASE_W'($urandom);
            lc = PHASE_W'($urandom);
        end else begin
            hc = phase_near(speed_level);
            lc = phase_near(speed_level);
        end
    endtask

    task automatic send_random_items(input int unsigned count);
        logic [ADC_W-1:0]   adc;
        logic [PHASE_W-1:0] hc;
        logic [PHASE_W-1:0] lc;
        repeat (count) begin
            make_random_item(adc, hc, lc);
            send_item(adc, hc, lc);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: field extremes, range edges, alternating bit patterns
    task automatic test_field_extremes();
        send_item(0, 2, 2);                  // smallest load, smallest pulse counts
        send_item(LOAD_FULL, 299, 299);      // top of load range, counts just under max
        send_item(LOAD_FULL + 1, 300, 300);  // load over range, both counts at max
        send_item(ADC_W'(PHASE_MAX), PHASE_W'(PHASE_MAX), PHASE_W'(PHASE_MAX));
        send_item(12800, 300, 299);          // only one count under max
        send_item(1, 1, 500);                // high phase at threshold: no pulse
        send_item(2, 500, 0);                // low phase zero: no pulse
        send_item(24, PHASE_W'(PHASE_MAX), 2);
        send_item(LOAD_FULL - 1, 2, PHASE_W'(PHASE_MAX));
        send_item(16384, 15'h5555, 15'h2AAA);
        send_item(8191, 15'h2AAA, 15'h5555);
        send_item(15'h4000, 15'h4000, 15'h0100);
        send_item(LOAD_FULL, 150, 150);
        send_item(LOAD_FULL, 150, 150);
        drain();
    endtask

    // No-pulse runs: tolerated up to the limit, then speed is forced to zero;
    // a pulse restarts the run.
    task automatic test_no_pulse_timeout();
        t_cfg c;
        c = default_config();
        c.zero_window_limit = 2;
        apply_config(c);
        repeat (4) send_item(LOAD_FULL / 2, 0, 200);   // last two forced to zero
        send_item(LOAD_FULL / 2, 120, 130);            // pulse: count restarts
        repeat (2) send_item(LOAD_FULL / 2, 200, 1);   // under the limit again
        send_item(LOAD_FULL / 2, 120, 130);
        drain();
        c.zero_window_limit = 0;
        apply_config(c);
        send_item(100, 1, 1);                          // first quiet window zeroes
        send_item(100, 120, 130);                      // refill from cleared taps
        drain();
    endtask

    // Threshold registers at both ends
    task automatic test_register_extremes();
        t_cfg c;
        c = default_config();
        c.zero_window_limit = 0;
        c.min_phase_count   = 0;
        c.max_phase_count   = MAXP_W'(PHASE_MAX);
        apply_config(c);
        send_item(500, 0, 40);                         // zero count: no pulse
        send_item(500, 1, 1);                          // one is a pulse now
        send_item(500, PHASE_W'(PHASE_MAX), PHASE_W'(PHASE_MAX));   // neither under max
        send_item(500, PHASE_W'(PHASE_MAX - 1), PHASE_W'(PHASE_MAX));
        drain();
        c.min_phase_count = MINP_W'((1 << MINP_W) - 1);
        c.max_phase_count = '0;
        apply_config(c);
        send_item(700, 255, 3000);                     // at threshold: no pulse
        send_item(700, 256, 256);                      // pulse, but max of zero blocks
        drain();
    endtask

    // Settle the load cascade at full scale, then saturate and zero the scale
    task automatic test_millivolt_scale();
        t_cfg c;
        c = default_config();
        c.mv_scale = '1;
        apply_config(c);
        repeat (25) send_item(LOAD_FULL, 200, 200);
        drain();
        c.mv_scale = '0;
        apply_config(c);
        repeat (3) send_item(LOAD_FULL, 200, 200);
        drain();
    endtask

    // Run the no-pulse counter into saturation with the largest limit, then
    // lower the limit under the saturated count.
    task automatic test_no_pulse_saturation();
        t_cfg c;
        c = default_config();
        c.zero_window_limit = '1;
        apply_config(c);
        repeat (270) send_item(ADC_W'($urandom), PHASE_W'($urandom_range(1)),
                               PHASE_W'($urandom));
        drain();
        c.zero_window_limit = ZLIM_W'((1 << ZLIM_W) - 2);
        apply_config(c);
        repeat (3) send_item(ADC_W'($urandom), PHASE_W'($urandom), 0);
        send_item(3000, 90, 95);
        drain();
    endtask

    // Random items in chunks, with a fresh register setting per chunk
    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input int unsigned chunks);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (chunks) begin
            apply_config(random_config());
            send_random_items(100);
            drain();
        end
    endtask

    // Hold the receiver off long enough for the block to fill and stall its
    // input while items keep being offered.
    task automatic test_output_backpressure();
        apply_config(default_config());
        @(posedge i_clk);
        rx_hold_left = 300;
        @(negedge i_clk);
        send_random_items(60);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        in_ch.valid      = 1'b0;
        in_ch.adc_sum    = '0;
        in_ch.high_count = '0;
        in_ch.low_count  = '0;
        out_ch.ready     = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_MV_SCALE;
        i_cfg_data       = '0;
        i_rst_n          = 1'b0;
        tx_idle_pct      = 6;
        rx_idle_pct      = 88;
        rx_hold_left     = 0;
        run_left         = 0;
        quiet_left       = 0;
        load_level       = 0;
        speed_level      = 0;
        items_sent       = 0;
        results_seen     = 0;
        load_updates     = 0;
        speed_updates    = 0;
        speed_timeouts   = 0;
        mismatches       = 0;
        stall_cycles     = 0;
        reset_predictor();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_field_extremes();
        test_no_pulse_timeout();
        test_register_extremes();
        test_millivolt_scale();
        test_no_pulse_saturation();
        // Sender mostly busy and receiver mostly stalled, then the reverse,
        // then both flat out.
        test_random_traffic(6, 88, 3);
        test_random_traffic(88, 6, 3);
        test_random_traffic(0, 0, 3);
        test_output_backpressure();

        // Any stray result after the last expected one is caught here
        in_ch.valid <= 1'b0;
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("covered %0d input transfers and %0d results, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("load updates %0d, speed updates %0d, forced-zero speeds %0d",
                 load_updates, speed_updates, speed_timeouts);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/ctm_pkg.sv
rtl/ctm_if.sv
rtl/ctm_queue.sv
rtl/ctm_front.sv
rtl/ctm_window.sv
rtl/ctm_back.sv
rtl/cascaded_trimmed_mean_load_and_speed.sv
test/tb_top.sv
